// ----- rtl/point_segment_proximity_test_defines.svh -----
// Assertion macros for the proximity test RTL.
`ifndef POINT_SEGMENT_PROXIMITY_TEST_DEFINES_SVH
`define POINT_SEGMENT_PROXIMITY_TEST_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PSP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define PSP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/psp_pkg.sv -----
// Shared types and constants of the point to segment proximity test.
`default_nettype none
package psp_pkg;
  localparam int TOL_BITS  = 27;
  localparam int DIST_BITS = 27;
  localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};
  localparam logic [TOL_BITS-1:0]  TOL_RESET = TOL_BITS'(256);

  // Result status codes; ST_FAR also marks an item still in range before the compare.
  localparam logic [1:0] ST_DEGEN   = 2'd0;
  localparam logic [1:0] ST_OUTSIDE = 2'd1;
  localparam logic [1:0] ST_FAR     = 2'd2;
  localparam logic [1:0] ST_MATCH   = 2'd3;

  // Register addresses.
  localparam logic [1:0] ADDR_TOLERANCE = 2'd0;

  // Control that travels with each item down the pipeline.
  typedef struct packed {
    logic       valid;
    logic [1:0] kind;
    logic       lam_one;
  } psp_ctl_t;
endpackage
`default_nettype wire

// ----- rtl/point_segment_proximity_test.sv -----
// Top level of the point to segment proximity test pipeline.
//
//   port group   direction   contents
//   in_*         input       point, segment start and end, 24-bit Q.8 each
//   out_*        output      status and L1 distance
//   APB          both        tolerance register at address 0
//
// One item is accepted every cycle while the pipeline is not held; a result passes
// through three front stages, one division step per lambda bit, and three back
// stages before it is shown.
// Reset is synchronous and clears all valid flags and the tolerance to 1.0.
// The whole pipeline holds while a result is shown and out_stall is high.
`default_nettype none
module point_segment_proximity_test import psp_pkg::*; #(
  parameter int COORD_BITS       = 24,
  parameter int LAMBDA_FRAC_BITS = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic signed [COORD_BITS-1:0] in_point_x,
  input  wire logic signed [COORD_BITS-1:0] in_point_y,
  input  wire logic signed [COORD_BITS-1:0] in_point_z,
  input  wire logic signed [COORD_BITS-1:0] in_start_x,
  input  wire logic signed [COORD_BITS-1:0] in_start_y,
  input  wire logic signed [COORD_BITS-1:0] in_start_z,
  input  wire logic signed [COORD_BITS-1:0] in_end_x,
  input  wire logic signed [COORD_BITS-1:0] in_end_y,
  input  wire logic signed [COORD_BITS-1:0] in_end_z,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [1:0]                        out_status,
  output logic [DIST_BITS-1:0]              out_distance,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [1:0]                   paddr,
  input  wire logic [31:0]                  pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
`include "point_segment_proximity_test_defines.svh"
  localparam int C  = COORD_BITS;
  localparam int F  = LAMBDA_FRAC_BITS;
  localparam int LW = 2 * C + 2;
  localparam int VW = 3 * (C + 1);

  logic                en;
  logic [TOL_BITS-1:0] tol_r;
  psp_ctl_t            ctl   [F+1];
  logic [LW-1:0]       rem   [F+1];
  logic [F-1:0]        quo   [F+1];
  logic [LW-1:0]       len   [F+1];
  logic [VW-1:0]       wv    [F+1];
  logic [VW-1:0]       dv    [F+1];

  // Pipeline advances unless a shown result is held back.
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // Tolerance register.
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_TOLERANCE) ? 32'(tol_r) : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_RESET;
    end else if (psel && penable && pwrite && pready && paddr == ADDR_TOLERANCE) begin
      tol_r <= pwdata[TOL_BITS-1:0];
    end
  end

  psp_front #(.C(C)) u_front (
    .clk(clk), .rst_n(rst_n), .en(en), .in_beat(in_valid),
    .px(in_point_x), .py(in_point_y), .pz(in_point_z),
    .sx(in_start_x), .sy(in_start_y), .sz(in_start_z),
    .ex(in_end_x), .ey(in_end_y), .ez(in_end_z),
    .ctl_o(ctl[0]), .rem_o(rem[0]), .len_o(len[0]), .w_o(wv[0]), .d_o(dv[0])
  );
  assign quo[0] = '0;

  // Divider chain: one quotient bit per cell.
  for (genvar k = 0; k < F; k++) begin : g_div
    psp_div_cell #(.LW(LW), .QW(F), .VW(VW)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .ctl_i(ctl[k]), .rem_i(rem[k]), .quo_i(quo[k]), .len_i(len[k]),
      .w_i(wv[k]), .d_i(dv[k]),
      .ctl_o(ctl[k+1]), .rem_o(rem[k+1]), .quo_o(quo[k+1]), .len_o(len[k+1]),
      .w_o(wv[k+1]), .d_o(dv[k+1])
    );
  end

  psp_back #(.C(C), .F(F)) u_back (
    .clk(clk), .rst_n(rst_n), .en(en),
    .ctl_i(ctl[F]), .quo_i(quo[F]), .w_i(wv[F]), .d_i(dv[F]),
    .tolerance(tol_r),
    .out_valid(out_valid), .out_status(out_status), .out_distance(out_distance)
  );

  // A rejected item never carries a distance.
  `PSP_ASSERT_IMP(a_zero_dist, out_valid && (out_status == ST_DEGEN || out_status == ST_OUTSIDE), out_distance == '0, "rejected item with nonzero distance")
  // A match is strictly below any tolerance, so never saturated.
  `PSP_ASSERT_IMP(a_match_unsat, out_valid && out_status == ST_MATCH, out_distance != DIST_MAX, "match at saturated distance")
  // A held result stays shown in the next cycle.
  `PSP_ASSERT_NXT(a_hold_pipe, out_valid && out_stall, out_valid && $stable(out_distance) && $stable(out_status), "held result changed")
endmodule
`default_nettype wire

// ----- rtl/psp_front.sv -----
// Front end: differences, products and span classification.
`default_nettype none
module psp_front import psp_pkg::*; #(
  parameter int C = 24
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  en,
  input  wire logic                  in_beat,
  input  wire logic signed [C-1:0]   px, py, pz, sx, sy, sz, ex, ey, ez,
  output psp_ctl_t                   ctl_o,
  output logic [2*C+1:0]             rem_o,
  output logic [2*C+1:0]             len_o,
  output logic [3*(C+1)-1:0]         w_o,
  output logic [3*(C+1)-1:0]         d_o
);
  localparam int DW = C + 1;
  localparam int PW = 2 * DW;
  localparam int LW = 2 * C + 2;
  localparam int SW = PW + 2;

  logic                 v1_r, v2_r;
  logic signed [DW-1:0] w1_r [3];
  logic signed [DW-1:0] d1_r [3];
  logic signed [DW-1:0] w2_r [3];
  logic signed [DW-1:0] d2_r [3];
  logic signed [PW-1:0] dd_r [3];
  logic signed [PW-1:0] wd_r [3];
  logic signed [C-1:0]  pv [3];
  logic signed [C-1:0]  sv [3];
  logic signed [C-1:0]  ev [3];
  logic signed [SW-1:0] len_s, dot_s;
  logic [1:0]           kind;

  assign pv = '{px, py, pz};
  assign sv = '{sx, sy, sz};
  assign ev = '{ex, ey, ez};

  // Stage one: offset and direction per axis.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_beat;
    end
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        w1_r[i] <= DW'(pv[i]) - DW'(sv[i]);
        d1_r[i] <= DW'(ev[i]) - DW'(sv[i]);
      end
    end
  end

  // Stage two: one multiplier per product.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dd_r[i] <= d1_r[i] * d1_r[i];
        wd_r[i] <= w1_r[i] * d1_r[i];
        w2_r[i] <= w1_r[i];
        d2_r[i] <= d1_r[i];
      end
    end
  end

  // Stage three: squared length, dot product and span check.
  always_comb begin
    len_s = SW'(dd_r[0]) + SW'(dd_r[1]) + SW'(dd_r[2]);
    dot_s = SW'(wd_r[0]) + SW'(wd_r[1]) + SW'(wd_r[2]);
    if (len_s == '0) begin
      kind = ST_DEGEN;
    end else if (dot_s < 0 || dot_s > len_s) begin
      kind = ST_OUTSIDE;
    end else begin
      kind = ST_FAR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_o.valid <= 1'b0;
    end else if (en) begin
      ctl_o.valid <= v2_r;
    end
    if (en) begin
      ctl_o.kind    <= kind;
      ctl_o.lam_one <= (dot_s == len_s);
      rem_o         <= dot_s[LW-1:0];
      len_o         <= len_s[LW-1:0];
      w_o           <= {w2_r[2], w2_r[1], w2_r[0]};
      d_o           <= {d2_r[2], d2_r[1], d2_r[0]};
    end
  end
endmodule
`default_nettype wire

// ----- rtl/psp_div_cell.sv -----
// One restoring division step of the lambda divider chain.
`default_nettype none
module psp_div_cell import psp_pkg::*; #(
  parameter int LW = 50,
  parameter int QW = 16,
  parameter int VW = 75
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  psp_ctl_t           ctl_i,
  input  wire logic [LW-1:0] rem_i,
  input  wire logic [QW-1:0] quo_i,
  input  wire logic [LW-1:0] len_i,
  input  wire logic [VW-1:0] w_i,
  input  wire logic [VW-1:0] d_i,
  output psp_ctl_t           ctl_o,
  output logic [LW-1:0]      rem_o,
  output logic [QW-1:0]      quo_o,
  output logic [LW-1:0]      len_o,
  output logic [VW-1:0]      w_o,
  output logic [VW-1:0]      d_o
);
  logic [LW:0] rem2, diff;
  logic        take;

  // Shift the remainder and subtract the divisor when it fits.
  always_comb begin
    rem2 = {rem_i, 1'b0};
    diff = rem2 - {1'b0, len_i};
    take = (rem2 >= {1'b0, len_i});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_o.valid <= 1'b0;
    end else if (en) begin
      ctl_o.valid <= ctl_i.valid;
    end
    if (en) begin
      ctl_o.kind    <= ctl_i.kind;
      ctl_o.lam_one <= ctl_i.lam_one;
      rem_o         <= take ? diff[LW-1:0] : rem2[LW-1:0];
      quo_o         <= {quo_i[QW-2:0], take};
      len_o         <= len_i;
      w_o           <= w_i;
      d_o           <= d_i;
    end
  end
endmodule
`default_nettype wire

// ----- rtl/psp_back.sv -----
// Back end: projected error per axis, L1 sum, saturation and status.
`default_nettype none
module psp_back import psp_pkg::*; #(
  parameter int C = 24,
  parameter int F = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  en,
  input  psp_ctl_t                   ctl_i,
  input  wire logic [F-1:0]          quo_i,
  input  wire logic [3*(C+1)-1:0]    w_i,
  input  wire logic [3*(C+1)-1:0]    d_i,
  input  wire logic [TOL_BITS-1:0]   tolerance,
  output logic                       out_valid,
  output logic [1:0]                 out_status,
  output logic [DIST_BITS-1:0]       out_distance
);
  localparam int DW   = C + 1;
  localparam int MW   = F + 2 + DW;
  localparam int EW   = DW + F + 2;
  localparam int SUMW = EW + 2;
  localparam int HW   = SUMW - F;
  localparam int CW   = (HW > DIST_BITS ? HW : DIST_BITS) + 1;

  psp_ctl_t             ca_r, cb_r;
  logic signed [MW-1:0] prod_r [3];
  logic signed [DW-1:0] wa_r [3];
  logic [EW-1:0]        mag_r [3];
  logic signed [F+1:0]  lam;
  logic signed [EW-1:0] err [3];
  logic [SUMW-1:0]      sum;
  logic [CW-1:0]        dist_w;
  logic [DIST_BITS-1:0] dist_sat;

  function automatic logic signed [F+1:0] ca_lam(input logic one, input logic [F-1:0] q);
    logic signed [F+1:0] r;
    r = one ? (F+2)'(1) <<< F : $signed({2'b00, q});
    return r;
  endfunction

  // Lambda as a signed operand; exactly one is a special code.
  assign lam = ca_lam(ctl_i.lam_one, quo_i);

  // Stage A: lambda times direction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ca_r.valid <= 1'b0;
    end else if (en) begin
      ca_r.valid <= ctl_i.valid;
    end
    if (en) begin
      ca_r.kind    <= ctl_i.kind;
      ca_r.lam_one <= ctl_i.lam_one;
      for (int i = 0; i < 3; i++) begin
        prod_r[i] <= lam * $signed(d_i[i*DW +: DW]);
        wa_r[i]   <= $signed(w_i[i*DW +: DW]);
      end
    end
  end

  // Stage B: exact per-axis error and its magnitude.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      err[i] = (EW'(wa_r[i]) <<< F) - EW'(prod_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cb_r.valid <= 1'b0;
    end else if (en) begin
      cb_r.valid <= ca_r.valid;
    end
    if (en) begin
      cb_r.kind    <= ca_r.kind;
      cb_r.lam_one <= ca_r.lam_one;
      for (int i = 0; i < 3; i++) begin
        mag_r[i] <= err[i][EW-1] ? EW'(-err[i]) : EW'(err[i]);
      end
    end
  end

  // Stage C: L1 sum, truncation to Q.8, saturation and tolerance compare.
  always_comb begin
    sum      = SUMW'(mag_r[0]) + SUMW'(mag_r[1]) + SUMW'(mag_r[2]);
    dist_w   = CW'(sum[SUMW-1:F]);
    dist_sat = (dist_w > CW'(DIST_MAX)) ? DIST_MAX : dist_w[DIST_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= cb_r.valid;
    end
    if (en) begin
      if (cb_r.kind == ST_FAR) begin
        out_status   <= (dist_sat < tolerance) ? ST_MATCH : ST_FAR;
        out_distance <= dist_sat;
      end else begin
        out_status   <= cb_r.kind;
        out_distance <= '0;
      end
    end
  end
endmodule
`default_nettype wire
